// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, idle in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ifm_pkg.sv =====
// ----------------------------------------------------------------------------
// ifm_pkg
// Types, constants and start-angle tables for the injector fire mask unit.
// ----------------------------------------------------------------------------
package ifm_pkg;

  localparam int AngleW = 13;
  localparam int MaskW  = 8;
  localparam int CountW = 4;
  localparam int WdataW = 4;
  localparam int DiffW  = AngleW + 1;

  // angles in tenths of a degree
  localparam int CycleTenths  = 7200;
  localparam int HalfTenths   = 3600;
  localparam int WindowTenths = 50;

  localparam logic [1:0]        ModeReset  = 2'd2;
  localparam logic [CountW-1:0] CountReset = 4'd4;

  typedef enum logic [1:0] {
    MODE_SEQ    = 2'd0,
    MODE_BATCH  = 2'd1,
    MODE_SIMUL  = 2'd2,
    MODE_SINGLE = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_MODE  = 1'b0,
    CFG_COUNT = 1'b1
  } cfg_idx_e;

  // first tenth of each cylinder's window: ceil(c*7200/n - 1800) mod 7200
  localparam logic [AngleW-1:0] SeqStart [0:8][0:7] = '{
    '{13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0},
    '{13'd5400, 13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0},
    '{13'd5400, 13'd1800, 13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0},
    '{13'd5400, 13'd600,  13'd3000, 13'd0,    13'd0,    13'd0,    13'd0,    13'd0},
    '{13'd5400, 13'd0,    13'd1800, 13'd3600, 13'd0,    13'd0,    13'd0,    13'd0},
    '{13'd5400, 13'd6840, 13'd1080, 13'd2520, 13'd3960, 13'd0,    13'd0,    13'd0},
    '{13'd5400, 13'd6600, 13'd600,  13'd1800, 13'd3000, 13'd4200, 13'd0,    13'd0},
    '{13'd5400, 13'd6429, 13'd258,  13'd1286, 13'd2315, 13'd3343, 13'd4372, 13'd0},
    '{13'd5400, 13'd6300, 13'd0,    13'd900,  13'd1800, 13'd2700, 13'd3600, 13'd4500}
  };

  // first tenth of each pair's window by pair count: p*3600/pairs
  localparam logic [AngleW-1:0] BatchStart [0:4][0:3] = '{
    '{13'd0, 13'd0,    13'd0,    13'd0},
    '{13'd0, 13'd0,    13'd0,    13'd0},
    '{13'd0, 13'd1800, 13'd0,    13'd0},
    '{13'd0, 13'd1200, 13'd2400, 13'd0},
    '{13'd0, 13'd900,  13'd1800, 13'd2700}
  };

  typedef struct packed {
    mode_e                         mode;
    logic [MaskW-1:0]              en;
    logic [MaskW-1:0][AngleW-1:0]  start;
  } ifm_cfg_t;

endpackage

// ===== rtl/core/ifm_cfg.sv =====
// ----------------------------------------------------------------------------
// ifm_cfg
// Mode and cylinder count registers; per-injector window start and enable.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifm_cfg
  import ifm_pkg::*;
#(
  parameter int MaxCylinders = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  cfg_idx_e          cfg_idx_i,
  input  logic [WdataW-1:0] cfg_wdata_i,
  output ifm_cfg_t          cfg_o
);

  mode_e             mode_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] n_used;
  logic [2:0]        pairs;
  logic [2:0]        lane_idx [MaskW];
  logic [1:0]        pair_idx [MaskW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mode_e'(ModeReset);
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:  mode_q  <= mode_e'(cfg_wdata_i[1:0]);
        CFG_COUNT: count_q <= cfg_wdata_i[CountW-1:0];
        default:   ;
      endcase
    end
  end

  assign n_used = (count_q > CountW'(MaxCylinders)) ? CountW'(MaxCylinders) : count_q;
  assign pairs  = n_used[3:1];

  always_comb begin
    for (int c = 0; c < MaskW; c++) begin
      lane_idx[c] = 3'(c);
      if (lane_idx[c] < pairs) begin
        pair_idx[c] = lane_idx[c][1:0];
      end else begin
        pair_idx[c] = 2'(lane_idx[c] - pairs);
      end
    end
  end

  always_comb begin
    cfg_o.mode  = mode_q;
    cfg_o.en    = '0;
    cfg_o.start = '0;
    unique case (mode_q)
      MODE_SEQ: begin
        cfg_o.en = MaskW'(~({MaskW{1'b1}} << n_used));
        for (int c = 0; c < MaskW; c++) begin
          cfg_o.start[c] = SeqStart[n_used][c];
        end
      end
      MODE_BATCH: begin
        cfg_o.en = MaskW'(~({MaskW{1'b1}} << {pairs, 1'b0}));
        for (int c = 0; c < MaskW; c++) begin
          cfg_o.start[c] = BatchStart[pairs][pair_idx[c]];
        end
      end
      MODE_SIMUL: begin
        cfg_o.en = MaskW'(~({MaskW{1'b1}} << n_used));
      end
      MODE_SINGLE: begin
        cfg_o.en = MaskW'(1);
      end
      default: ;
    endcase
  end

  `ASSERT_ALWAYS(a_en_low_run, (cfg_o.en & (cfg_o.en + MaskW'(1))) == '0)
  `ASSERT_IMPLIES(a_single_lane0, mode_q == MODE_SINGLE, cfg_o.en == MaskW'(1))
  `ASSERT_ALWAYS(a_count_clamp, n_used <= CountW'(MaxCylinders))

endmodule

// ===== rtl/core/ifm_lane.sv =====
// ----------------------------------------------------------------------------
// ifm_lane
// Window compare for one injector against its start angle.
// ----------------------------------------------------------------------------
module ifm_lane
  import ifm_pkg::*;
(
  input  logic [AngleW-1:0] angle_i,
  input  logic [AngleW-1:0] start_i,
  input  mode_e             mode_i,
  input  logic              en_i,
  output logic              hit_o
);

  logic signed [DiffW-1:0] diff;
  logic                    in_main;
  logic                    in_fwd_cycle;
  logic                    in_back_cycle;
  logic                    in_half;

  assign diff = $signed({1'b0, angle_i}) - $signed({1'b0, start_i});

  assign in_main       = (diff >= 0) && (diff < DiffW'(WindowTenths));
  assign in_fwd_cycle  = (diff >= DiffW'(CycleTenths)) &&
                         (diff <  DiffW'(CycleTenths + WindowTenths));
  assign in_back_cycle = (diff >= -DiffW'(CycleTenths)) &&
                         (diff <  -DiffW'(CycleTenths - WindowTenths));
  assign in_half       = (diff >= DiffW'(HalfTenths)) &&
                         (diff <  DiffW'(HalfTenths + WindowTenths));

  always_comb begin
    unique case (mode_i)
      MODE_SEQ:   hit_o = en_i && (in_main || in_fwd_cycle || in_back_cycle);
      MODE_BATCH: hit_o = en_i && (in_main || in_half);
      default:    hit_o = en_i && in_main;
    endcase
  end

endmodule

// ===== rtl/core/injector_fire_mask_by_crank_angle_unit.sv =====
// ----------------------------------------------------------------------------
// injector_fire_mask_by_crank_angle_unit
// Crank angle in, injector fire mask out, by mode and cylinder count.
// ----------------------------------------------------------------------------
// One crank angle request is taken per clock while the output is not stalled.
// An input register feeds one row of window comparators (one per
// injector) whose outputs land in the result register. Window starts come
// straight from constant tables indexed by the configured cylinder count, so
// a configuration write is effective on the next request. No clearing pass.
`include "assert_macros.svh"

module injector_fire_mask_by_crank_angle_unit
  import ifm_pkg::*;
#(
  parameter int MaxCylinders = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [12:0] angle in tenths, [15:13] zero
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [MaskW-1:0]  m_axis_tdata,   // [7:0] fire mask
  input  logic              cfg_we_i,
  input  cfg_idx_e          cfg_idx_i,
  input  logic [WdataW-1:0] cfg_wdata_i
);

  ifm_cfg_t          cfg;
  logic              s1_valid_q, s1_valid_d;
  logic [AngleW-1:0] s1_angle_q;
  logic              res_valid_q, res_valid_d;
  logic [MaskW-1:0]  res_mask_q;
  logic [MaskW-1:0]  hit;
  logic              res_ready;
  logic              s1_ready;
  logic              s1_load;
  logic              res_load;

  ifm_cfg #(
    .MaxCylinders(MaxCylinders)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  for (genvar c = 0; c < MaskW; c++) begin : g_lane
    if (c < MaxCylinders) begin : g_on
      ifm_lane u_lane (
        .angle_i(s1_angle_q),
        .start_i(cfg.start[c]),
        .mode_i (cfg.mode),
        .en_i   (cfg.en[c]),
        .hit_o  (hit[c])
      );
    end else begin : g_off
      assign hit[c] = 1'b0;
    end
  end

  assign res_ready     = !res_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || res_ready;
  assign s1_load       = s_axis_tvalid && s1_ready;
  assign res_load      = s1_valid_q && res_ready;
  assign s_axis_tready = s1_ready;
  assign s1_valid_d    = s1_ready ? s_axis_tvalid : s1_valid_q;
  assign res_valid_d   = res_ready ? s1_valid_q : res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_angle_q <= s_axis_tdata[AngleW-1:0];
    end
    if (res_load) begin
      res_mask_q <= hit;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_mask_q;

  `ASSERT_NEXT(a_res_follows, res_load, res_valid_q)
  `ASSERT_NEXT(a_s1_hold, s1_valid_q && !res_ready, s1_valid_q && $stable(s1_angle_q))
  `ASSERT_NEXT(a_mask_in_en, res_load, (res_mask_q & ~$past(cfg.en)) == '0)

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Injector fire mask testbench
// Drives crank angle requests over several mode and cylinder count settings,
// with random gaps on both sides, and checks every mask against a local
// prediction held in a small scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  import ifm_pkg::*;

  localparam int IntakeTenths = 1800;
  localparam int NumPhases    = 20;
  localparam int PhaseItems   = 78;
  localparam int AngleMax     = 8191;

  class fire_mask_scoreboard;
    mode_e            mode;
    logic [3:0]       count;
    logic [7:0]       expected_masks[$];
    int               errors;

    function new();
      mode   = MODE_SIMUL;
      count  = CountReset;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void write_reg(cfg_idx_e idx, logic [3:0] val);
      if (idx == CFG_MODE) mode = mode_e'(val[1:0]);
      else count = val;
    endfunction

    function logic [7:0] fire_mask(logic [12:0] angle);
      int a, n, pairs, target, diff, d1, d2;
      logic [7:0] m;
      m = '0;
      a = angle;
      n = (count > 8) ? 8 : count;
      case (mode)
        MODE_SEQ: begin
          // scaled by n so the window start is exact
          for (int c = 0; c < n; c++) begin
            target = c * CycleTenths - IntakeTenths * n;
            if (target < 0) target += CycleTenths * n;
            diff = a * n - target;
            if (diff > HalfTenths * n) diff -= CycleTenths * n;
            if (diff < -HalfTenths * n) diff += CycleTenths * n;
            if (diff >= 0 && diff < WindowTenths * n) m[c] = 1'b1;
          end
        end
        MODE_BATCH: begin
          pairs = n / 2;
          for (int p = 0; p < pairs; p++) begin
            d1 = a * pairs - p * HalfTenths;
            d2 = d1 - HalfTenths * pairs;
            if ((d1 >= 0 && d1 < WindowTenths * pairs) ||
                (d2 >= 0 && d2 < WindowTenths * pairs)) begin
              m[p]         = 1'b1;
              m[p + pairs] = 1'b1;
            end
          end
        end
        MODE_SIMUL: begin
          if (a < WindowTenths) begin
            for (int c = 0; c < n; c++) m[c] = 1'b1;
          end
        end
        default: begin
          if (a < WindowTenths) m = 8'h01;
        end
      endcase
      return m;
    endfunction

    function void note_angle(logic [12:0] angle);
      expected_masks.push_back(fire_mask(angle));
    endfunction

    task check_mask(logic [7:0] got);
      logic [7:0] want;
      if (expected_masks.size() == 0) begin
        report($sformatf("mask %02h with no request pending", got));
      end else begin
        want = expected_masks.pop_front();
        if (got !== want)
          report($sformatf("fire mask got %02h want %02h", got, want));
      end
    endtask

    task close();
      if (expected_masks.size() != 0)
        report($sformatf("%0d masks never arrived", expected_masks.size()));
    endtask

    function int pending();
      return expected_masks.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [12:0] angle in tenths, [15:13] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;   // [7:0] fire mask
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [3:0]  cfg_wdata_i;
  logic        calm;

  fire_mask_scoreboard sb;

  mode_e phase_mode [NumPhases] = '{
    MODE_SEQ, MODE_BATCH, MODE_SIMUL, MODE_SINGLE, MODE_SEQ,
    MODE_BATCH, MODE_SEQ, MODE_BATCH, MODE_SIMUL, MODE_SEQ,
    MODE_BATCH, MODE_SINGLE, MODE_SEQ, MODE_BATCH, MODE_SIMUL,
    MODE_SEQ, MODE_SEQ, MODE_BATCH, MODE_SIMUL, MODE_SEQ
  };
  int phase_count [NumPhases] = '{
    8, 8, 8, 8, 7, 6, 1, 5, 0, 15, 2, 3, 5, 4, 1, 6, 3, 15, 13, 2
  };

  injector_fire_mask_by_crank_angle_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_angle(s_axis_tdata[12:0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_mask(m_axis_tdata);
    end
  end

  task send_angle(int angle);
    while (!calm && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, 13'(angle)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // hold requests back until every mask is in, then let the pipe settle
  task drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task configure(mode_e m, int n);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MODE;
    cfg_wdata_i <= {2'($urandom_range(0, 3)), m};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_COUNT;
    cfg_wdata_i <= 4'(n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly angles around a window edge, the rest anywhere in the field
  function automatic int pick_angle(mode_e m, int count);
    int n, pairs, base, off, a;
    n = (count > 8) ? 8 : count;
    if (n == 0 || $urandom_range(0, 99) < 30) return $urandom_range(0, AngleMax);
    off = int'($urandom_range(0, 60)) - 5;
    case (m)
      MODE_SEQ: begin
        base = (int'($urandom_range(0, n - 1)) * CycleTenths / n + 5400) % CycleTenths;
      end
      MODE_BATCH: begin
        pairs = n / 2;
        if (pairs == 0) base = 0;
        else base = int'($urandom_range(0, pairs - 1)) * HalfTenths / pairs
                    + HalfTenths * int'($urandom_range(0, 1));
      end
      default: base = 0;
    endcase
    a = base + off;
    if (a < 0) a += CycleTenths;
    return a % (AngleMax + 1);
  endfunction

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MODE;
    cfg_wdata_i   = '0;
    calm          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: simultaneous, four cylinders
    send_angle(0);
    send_angle(49);
    send_angle(50);
    send_angle(AngleMax);
    configure(MODE_SEQ, 8);
    send_angle(5400);
    send_angle(5449);
    send_angle(5450);
    send_angle(5399);
    send_angle(0);
    send_angle(7199);
    send_angle(AngleMax);
    // odd count in batch: last cylinder left out
    configure(MODE_BATCH, 3);
    send_angle(0);
    send_angle(3600);
    send_angle(3649);
    send_angle(3650);
    configure(MODE_BATCH, 1);
    send_angle(0);
    // single point ignores the count
    configure(MODE_SINGLE, 0);
    send_angle(0);
    send_angle(50);
    configure(MODE_SEQ, 0);
    send_angle(5400);
    configure(MODE_SIMUL, 15);
    send_angle(0);
    send_angle(7200);
    configure(MODE_SEQ, 7);
    send_angle(257);
    send_angle(258);

    for (int ph = 0; ph < NumPhases; ph++) begin
      configure(phase_mode[ph], phase_count[ph]);
      calm = (ph == 10);
      for (int i = 0; i < PhaseItems; i++)
        send_angle(pick_angle(phase_mode[ph], phase_count[ph]));
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk_i);
    sb.close();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
